@@ rtl/core/mhpq_pkg.sv @@
// Shared constants and types for the min-heap priority queue.
// No dependencies; imported by all core modules.
`timescale 1ns / 1ps

package mhpq_pkg;

   // heap geometry
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int IDX_W    = ADDR_W + 2;
   localparam int KEY_W    = 32;

   // command codes
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   // key returned when an extract finds the heap empty
   localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

   // memory access request from the sequencer
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_req_type;

endpackage

@@ rtl/core/min_heap_priority_queue_top.sv @@
// Min-heap priority queue of signed 32-bit keys.
//
// Usage: drive req_command (0 insert, 1 extract) and req_key_value with
// start high; the item is taken at an edge where busy is low. Insert gives
// no result; an insert into a full heap (1024 keys) is dropped and busy
// stays low. Extract gives one result: rsp_valid is high for exactly one
// cycle with rsp_extracted_key and rsp_was_empty. An extract on an empty
// heap returns -1 with rsp_was_empty set.
// rsp_valid is registered: after a non-empty extract it rises once the
// states S_EX_RD and S_EX_EV have passed, or at the accepting edge itself
// when the heap is empty. Busy stays high while the key is sifted, and no
// new item is taken until it falls. Each level is one read of the key
// store, then a compare and a write-back in the next cycle; the next read
// is issued only after that write-back. Insert climbs level by level and
// ends with a write at the root or a final compare below it. Extract first
// reads the root and the last entry, then descends level by level and
// ends with a write at a leaf or a final compare, or at once when the heap
// is left empty.
// Reset empties the heap at once; the key store is not cleared.
// The receiver cannot stall: results are never held.
`timescale 1ns / 1ps

module min_heap_priority_queue_top
   import mhpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic signed [KEY_W-1:0] req_key_value,
   output logic                    rsp_valid,
   output logic signed [KEY_W-1:0] rsp_extracted_key,
   output logic                    rsp_was_empty
);

   mem_req_type      mem_req;
   logic [KEY_W-1:0] rdata_a;
   logic [KEY_W-1:0] rdata_b;

   // sift sequencer
   mhpq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_key_value     (req_key_value),
      .rsp_extracted_key (rsp_extracted_key),
      .rsp_was_empty     (rsp_was_empty),
      .rsp_valid         (rsp_valid),
      .mem_req           (mem_req),
      .rdata_a           (rdata_a),
      .rdata_b           (rdata_b)
   );

   // key store
   mhpq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

endmodule

@@ rtl/core/mhpq_ram.sv @@
// Heap key store: one write port, two read ports, registered read data.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ram
   import mhpq_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [KEY_W-1:0]  rdata_a,
   output logic [KEY_W-1:0]  rdata_b
);

   logic [KEY_W-1:0] mem_array [CAPACITY];

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_array[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // two read ports, registered read data
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_a <= mem_array[mem_req.raddr_a];
         rdata_b <= mem_array[mem_req.raddr_b];
      end
   end

endmodule

@@ rtl/core/mhpq_ctrl.sv @@
// Sift sequencer: holds the moving key and walks the heap one level per
// read/compare/write pair. Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic signed [KEY_W-1:0] req_key_value,
   output logic signed [KEY_W-1:0] rsp_extracted_key,
   output logic                    rsp_was_empty,
   output logic                    rsp_valid,
   output mem_req_type             mem_req,
   input  logic [KEY_W-1:0]        rdata_a,
   input  logic [KEY_W-1:0]        rdata_b
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UP_RD = 3'd1;
   localparam logic [2:0] S_UP_EV = 3'd2;
   localparam logic [2:0] S_EX_RD = 3'd3;
   localparam logic [2:0] S_EX_EV = 3'd4;
   localparam logic [2:0] S_DN_RD = 3'd5;
   localparam logic [2:0] S_DN_EV = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;

   logic [IDX_W-1:0]  left_idx, right_idx, count_ext;
   logic              left_ok, right_ok, pick_right, child_less;
   logic [KEY_W-1:0]  child_key;
   logic [ADDR_W-1:0] child_pos, parent_pos;
   logic              accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);

   // neighbor indices of the current position
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + IDX_W'(1);
   assign count_ext  = IDX_W'(count_ff);
   assign left_ok    = left_idx < count_ext;
   assign right_ok   = right_idx < count_ext;
   assign parent_pos = (pos_ff - ADDR_W'(1)) >> 1;

   // smaller child, left wins ties
   assign pick_right = right_ok && ($signed(rdata_b) < $signed(rdata_a));
   assign child_key  = pick_right ? rdata_b : rdata_a;
   assign child_pos  = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
   assign child_less = $signed(child_key) < $signed(key_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_empty_in = rsp_empty_ff;
      rsp_key_in   = rsp_key_ff;
      mem_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_INSERT) begin
                  if (count_ff != CNT_W'(CAPACITY)) begin
                     pos_in   = count_ff[ADDR_W-1:0];
                     key_in   = req_key_value;
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_empty_in = 1'b1;
                  rsp_key_in   = EMPTY_KEY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_EX_RD;
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               mem_req.wdata = key_ff;
               state_in      = S_IDLE;
            end else begin
               mem_req.re      = 1'b1;
               mem_req.raddr_a = parent_pos;
               mem_req.raddr_b = parent_pos;
               state_in        = S_UP_EV;
            end
         end
         S_UP_EV: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if ($signed(key_ff) < $signed(rdata_a)) begin
               mem_req.wdata = rdata_a;
               pos_in        = parent_pos;
               state_in      = S_UP_RD;
            end else begin
               mem_req.wdata = key_ff;
               state_in      = S_IDLE;
            end
         end
         S_EX_RD: begin
            // root and last live entry
            mem_req.re      = 1'b1;
            mem_req.raddr_a = '0;
            mem_req.raddr_b = count_ff[ADDR_W-1:0];
            state_in        = S_EX_EV;
         end
         S_EX_EV: begin
            rsp_valid_in = 1'b1;
            rsp_empty_in = 1'b0;
            rsp_key_in   = rdata_a;
            key_in       = rdata_b;
            pos_in       = '0;
            state_in     = (count_ff == '0) ? S_IDLE : S_DN_RD;
         end
         S_DN_RD: begin
            if (!left_ok) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff;
               mem_req.wdata = key_ff;
               state_in      = S_IDLE;
            end else begin
               mem_req.re      = 1'b1;
               mem_req.raddr_a = left_idx[ADDR_W-1:0];
               mem_req.raddr_b = right_idx[ADDR_W-1:0];
               state_in        = S_DN_EV;
            end
         end
         S_DN_EV: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (child_less) begin
               mem_req.wdata = child_key;
               pos_in        = child_pos;
               state_in      = S_DN_RD;
            end else begin
               mem_req.wdata = key_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_empty     = rsp_empty_ff;
   assign rsp_extracted_key = rsp_key_ff;

endmodule
